// ===== rtl/rvex_pkg.sv =====
// rvex_pkg: operation codes, alu helpers and the result record of the rv32i execute unit
// no dependencies; used by the channel interfaces and by rv32i_execute_unit
package rvex_pkg;

  localparam int XLEN      = 32;
  localparam int REG_AW    = 5;
  localparam int FUNC_W    = 6;
  localparam int IMM_W     = 21;
  localparam int OUT_DEPTH = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD   = 6'd0,  FN_SUB   = 6'd1,  FN_SLL   = 6'd2,  FN_SLT   = 6'd3,
    FN_SLTU  = 6'd4,  FN_XOR   = 6'd5,  FN_SRL   = 6'd6,  FN_SRA   = 6'd7,
    FN_OR    = 6'd8,  FN_AND   = 6'd9,  FN_ADDI  = 6'd10, FN_SLTI  = 6'd11,
    FN_SLTIU = 6'd12, FN_XORI  = 6'd13, FN_ORI   = 6'd14, FN_ANDI  = 6'd15,
    FN_SLLI  = 6'd16, FN_SRLI  = 6'd17, FN_SRAI  = 6'd18, FN_LB    = 6'd19,
    FN_LH    = 6'd20, FN_LW    = 6'd21, FN_LBU   = 6'd22, FN_LHU   = 6'd23,
    FN_JALR  = 6'd24, FN_SB    = 6'd25, FN_SH    = 6'd26, FN_SW    = 6'd27,
    FN_BEQ   = 6'd28, FN_BNE   = 6'd29, FN_BLT   = 6'd30, FN_BGE   = 6'd31,
    FN_BLTU  = 6'd32, FN_BGEU  = 6'd33, FN_LUI   = 6'd34, FN_AUIPC = 6'd35,
    FN_JAL   = 6'd36
  } func_t;

  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU,
    ALU_XOR, ALU_SRL, ALU_SRA, ALU_OR, ALU_AND
  } alu_op_t;

  typedef struct packed {
    logic              reg_write;
    logic [REG_AW-1:0] write_index;
    logic [XLEN-1:0]   write_value;
    logic [XLEN-1:0]   next_pc;
    logic              branch_taken;
  } result_t;

  function automatic alu_op_t alu_op_of(logic [FUNC_W-1:0] func);
    alu_op_t op;
    case (func)
      FN_ADD, FN_ADDI:   op = ALU_ADD;
      FN_SUB:            op = ALU_SUB;
      FN_SLL, FN_SLLI:   op = ALU_SLL;
      FN_SLT, FN_SLTI:   op = ALU_SLT;
      FN_SLTU, FN_SLTIU: op = ALU_SLTU;
      FN_XOR, FN_XORI:   op = ALU_XOR;
      FN_SRL, FN_SRLI:   op = ALU_SRL;
      FN_SRA, FN_SRAI:   op = ALU_SRA;
      FN_OR, FN_ORI:     op = ALU_OR;
      default:           op = ALU_AND;
    endcase
    return op;
  endfunction

  function automatic logic [XLEN-1:0] alu_eval(alu_op_t op, logic [XLEN-1:0] a,
                                               logic [XLEN-1:0] b);
    logic [4:0]      sh;
    logic [XLEN-1:0] r;
    sh = b[4:0];
    case (op)
      ALU_ADD:  r = a + b;
      ALU_SUB:  r = a - b;
      ALU_SLL:  r = a << sh;
      ALU_SLT:  r = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
      ALU_SLTU: r = {{(XLEN-1){1'b0}}, a < b};
      ALU_XOR:  r = a ^ b;
      ALU_SRL:  r = a >> sh;
      ALU_SRA:  r = $unsigned($signed(a) >>> sh);
      ALU_OR:   r = a | b;
      default:  r = a & b;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/rvex_instr_if.sv =====
// rvex_instr_if: valid/ready channel carrying one decoded instruction
// depends on rvex_pkg
interface rvex_instr_if import rvex_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [REG_AW-1:0]       dest_index;
  logic [REG_AW-1:0]       src1_index;
  logic [REG_AW-1:0]       src2_index;
  logic signed [IMM_W-1:0] immediate;

  modport source (output valid, func, dest_index, src1_index, src2_index, immediate,
                  input ready);
  modport sink (input valid, func, dest_index, src1_index, src2_index, immediate,
                output ready);
endinterface

// ===== rtl/rvex_result_if.sv =====
// rvex_result_if: valid/ready channel carrying one execute result
// depends on rvex_pkg
interface rvex_result_if import rvex_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              reg_write;
  logic [REG_AW-1:0] write_index;
  logic [XLEN-1:0]   write_value;
  logic [XLEN-1:0]   next_pc;
  logic              branch_taken;

  modport source (output valid, reg_write, write_index, write_value, next_pc, branch_taken,
                  input ready);
  modport sink (input valid, reg_write, write_index, write_value, next_pc, branch_taken,
                output ready);
endinterface

// ===== rtl/rvex_ram.sv =====
// rvex_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies; read during a write to the same address returns the old data
module rvex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/rv32i_execute_unit.sv =====
// rv32i_execute_unit: rv32i execute stage with register file, pc and byte data memory
// depends on rvex_pkg, rvex_instr_if, rvex_result_if and rvex_ram
//
//   channel | dir | transaction
//   instr   | in  | func, dest_index, src1_index, src2_index, immediate
//   result  | out | reg_write, write_index, write_value, next_pc, branch_taken
//
// one instruction per cycle while instr.ready is high; each result passes stage 1, stage 2 and the output queue
// register file reads issue at acceptance, alu/branch/address work in stage 1,
// load data returns from the four byte-lane rams in stage 2, then a 4-deep output queue
// register and load results are forwarded from stage 2 and the last write back
// rst is synchronous; register valid bits, pc and queue clear; data memory is not cleared
// instr.ready is low in reset and when four items sit in the pipe and queue
// MEM_BYTES must be a power of two
module rv32i_execute_unit import rvex_pkg::*; #(
  parameter int MEM_BYTES = 4096
) (
  input logic          clk,
  input logic          rst,
  rvex_instr_if.sink   instr,
  rvex_result_if.source result
);
  localparam int AW     = $clog2(MEM_BYTES);
  localparam int ROWS   = MEM_BYTES / 4;
  localparam int RW     = AW - 2;
  localparam int OUT_AW = $clog2(OUT_DEPTH);

  // stage 1
  logic                    s1_valid;
  logic [FUNC_W-1:0]       s1_func;
  logic [REG_AW-1:0]       s1_rd, s1_rs1, s1_rs2;
  logic [IMM_W-1:0]        s1_imm;
  logic                    s1_v1, s1_v2;
  logic [XLEN-1:0]         rf_q1, rf_q2;
  // stage 2
  logic                    s2_valid;
  logic                    s2_wr;
  logic                    s2_load;
  logic [REG_AW-1:0]       s2_rd;
  logic [XLEN-1:0]         s2_val;
  logic [FUNC_W-1:0]       s2_func;
  logic [1:0]              s2_ea_lo;
  logic [XLEN-1:0]         s2_npc;
  logic                    s2_taken;
  logic [XLEN-1:0]         s2_final;
  // architectural state around the rams
  logic [XLEN-1:0]         prog_counter;
  logic [31:0]             rf_valid;
  logic                    lw_valid;
  logic [REG_AW-1:0]       lw_idx;
  logic [XLEN-1:0]         lw_val;
  // output queue
  result_t                 oq [OUT_DEPTH];
  logic [OUT_AW-1:0]       oq_wptr, oq_rptr;
  logic [OUT_AW:0]         oq_count, oq_count_next, occupancy;
  logic                    oq_pop;
  result_t                 oq_head, s2_res;

  // stage 1 combinational
  logic [XLEN-1:0]         a, b, imm32, upper, op2, pc_plus4, br_target, ea;
  logic [XLEN-1:0]         val, npc;
  logic                    wr, taken, cond, is_load, is_store;
  logic [2:0]              nbytes;
  // byte lanes
  logic                    lane_we    [4];
  logic [RW-1:0]           lane_addr  [4];
  logic [7:0]              lane_wdata [4];
  logic [7:0]              lane_q     [4];
  logic [7:0]              ld_bytes   [4];
  logic [XLEN-1:0]         ld_word, ld_val;

  logic                    accept, rf_we;

  assign accept      = instr.valid && instr.ready;
  assign occupancy   = oq_count + (OUT_AW+1)'(s1_valid) + (OUT_AW+1)'(s2_valid);
  assign instr.ready = !rst && (occupancy < (OUT_AW+1)'(OUT_DEPTH));
  assign rf_we       = s2_valid && s2_wr;

  // register file: two copies give two read ports
  rvex_ram #(.WIDTH(XLEN), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(s2_rd), .wdata(s2_final),
    .raddr(instr.src1_index), .rdata(rf_q1)
  );
  rvex_ram #(.WIDTH(XLEN), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(s2_rd), .wdata(s2_final),
    .raddr(instr.src2_index), .rdata(rf_q2)
  );

  // operand forwarding: stage 2 first, then the write done at the read edge
  always_comb begin
    if (rf_we && s2_rd == s1_rs1) begin
      a = s2_final;
    end else if (lw_valid && lw_idx == s1_rs1) begin
      a = lw_val;
    end else begin
      a = s1_v1 ? rf_q1 : '0;
    end
    if (rf_we && s2_rd == s1_rs2) begin
      b = s2_final;
    end else if (lw_valid && lw_idx == s1_rs2) begin
      b = lw_val;
    end else begin
      b = s1_v2 ? rf_q2 : '0;
    end
  end

  always_comb begin
    imm32     = {{(XLEN-IMM_W){s1_imm[IMM_W-1]}}, s1_imm};
    upper     = {s1_imm[19:0], 12'b0};
    pc_plus4  = prog_counter + 32'd4;
    br_target = prog_counter + imm32;
    ea        = a + imm32;
    op2       = (s1_func <= FN_AND) ? b : imm32;
    val       = '0;
    wr        = 1'b0;
    taken     = 1'b0;
    cond      = 1'b0;
    npc       = pc_plus4;
    is_load   = 1'b0;
    is_store  = 1'b0;
    nbytes    = 3'd0;
    if (s1_func <= FN_SRAI) begin
      val = alu_eval(alu_op_of(s1_func), a, op2);
      wr  = 1'b1;
    end else begin
      case (s1_func)
        FN_LB, FN_LH, FN_LW, FN_LBU, FN_LHU: begin
          is_load = 1'b1;
          wr      = 1'b1;
        end
        FN_JALR: begin
          val   = pc_plus4;
          wr    = 1'b1;
          npc   = {ea[XLEN-1:1], 1'b0};
          taken = 1'b1;
        end
        FN_SB: begin
          is_store = 1'b1;
          nbytes   = 3'd1;
        end
        FN_SH: begin
          is_store = 1'b1;
          nbytes   = 3'd2;
        end
        FN_SW: begin
          is_store = 1'b1;
          nbytes   = 3'd4;
        end
        FN_BEQ:  cond = (a == b);
        FN_BNE:  cond = (a != b);
        FN_BLT:  cond = ($signed(a) < $signed(b));
        FN_BGE:  cond = !($signed(a) < $signed(b));
        FN_BLTU: cond = (a < b);
        FN_BGEU: cond = (a >= b);
        FN_LUI: begin
          val = upper;
          wr  = 1'b1;
        end
        FN_AUIPC: begin
          val = prog_counter + upper;
          wr  = 1'b1;
        end
        FN_JAL: begin
          val   = pc_plus4;
          wr    = 1'b1;
          npc   = br_target;
          taken = 1'b1;
        end
        default: ;
      endcase
      if (cond) begin
        npc   = br_target;
        taken = 1'b1;
      end
    end
  end

  // lane l holds bytes whose address is l mod 4; each access byte lands in its own lane
  always_comb begin
    logic [1:0] lane_off;
    lane_off = '0;
    for (int l = 0; l < 4; l++) begin
      lane_off      = 2'(l) - ea[1:0];
      lane_addr[l]  = ea[AW-1:2] + RW'(2'(l) < ea[1:0]);
      lane_we[l]    = s1_valid && is_store && ({1'b0, lane_off} < nbytes);
      lane_wdata[l] = b[{lane_off, 3'b000} +: 8];
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    rvex_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
      .clk(clk), .we(lane_we[l]), .waddr(lane_addr[l]), .wdata(lane_wdata[l]),
      .raddr(lane_addr[l]), .rdata(lane_q[l])
    );
  end

  // load data: rotate lanes back into byte order, then extend
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_bytes[i] = lane_q[2'(s2_ea_lo + 2'(i))];
    end
    ld_word = {ld_bytes[3], ld_bytes[2], ld_bytes[1], ld_bytes[0]};
    case (s2_func)
      FN_LB:   ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
      FN_LH:   ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
      FN_LBU:  ld_val = {24'b0, ld_word[7:0]};
      FN_LHU:  ld_val = {16'b0, ld_word[15:0]};
      default: ld_val = ld_word;
    endcase
    s2_final = s2_load ? ld_val : s2_val;
  end

  always_comb begin
    s2_res.reg_write    = s2_wr;
    s2_res.write_index  = s2_rd;
    s2_res.write_value  = s2_wr ? s2_final : '0;
    s2_res.next_pc      = s2_npc;
    s2_res.branch_taken = s2_taken;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      prog_counter <= '0;
      rf_valid     <= '0;
      lw_valid     <= 1'b0;
      oq_wptr      <= '0;
      oq_rptr      <= '0;
      oq_count     <= '0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (s1_valid) begin
        prog_counter <= npc;
      end
      if (rf_we) begin
        rf_valid[s2_rd] <= 1'b1;
        lw_valid        <= 1'b1;
      end
      if (s2_valid) begin
        oq_wptr <= oq_wptr + 1'b1;
      end
      if (oq_pop) begin
        oq_rptr <= oq_rptr + 1'b1;
      end
      oq_count <= oq_count_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_func  <= instr.func;
    s1_rd    <= instr.dest_index;
    s1_rs1   <= instr.src1_index;
    s1_rs2   <= instr.src2_index;
    s1_imm   <= instr.immediate;
    s1_v1    <= rf_valid[instr.src1_index];
    s1_v2    <= rf_valid[instr.src2_index];
    s2_wr    <= wr && (s1_rd != '0);
    s2_rd    <= (wr && (s1_rd != '0)) ? s1_rd : '0;
    s2_val   <= val;
    s2_load  <= is_load;
    s2_func  <= s1_func;
    s2_ea_lo <= ea[1:0];
    s2_npc   <= npc;
    s2_taken <= taken;
    if (rf_we) begin
      lw_idx <= s2_rd;
      lw_val <= s2_final;
    end
    if (s2_valid) begin
      oq[oq_wptr] <= s2_res;
    end
  end

  // output queue
  assign oq_pop  = result.valid && result.ready;
  assign oq_head = oq[oq_rptr];

  always_comb begin
    oq_count_next = oq_count;
    if (s2_valid && !oq_pop) begin
      oq_count_next = oq_count + 1'b1;
    end else if (!s2_valid && oq_pop) begin
      oq_count_next = oq_count - 1'b1;
    end
  end

  assign result.valid        = (oq_count != '0);
  assign result.reg_write    = oq_head.reg_write;
  assign result.write_index  = oq_head.write_index;
  assign result.write_value  = oq_head.write_value;
  assign result.next_pc      = oq_head.next_pc;
  assign result.branch_taken = oq_head.branch_taken;

endmodule

// ===== test/tb_rv32i_execute_unit.sv =====
// tb_rv32i_execute_unit: self-checking testbench for the rv32i execute unit
// drives decoded instructions, predicts register writes, pc and memory, checks every result
// depends on rvex_pkg, rvex_instr_if, rvex_result_if and rv32i_execute_unit
`timescale 1ns / 100ps

module tb_rv32i_execute_unit;
  import rvex_pkg::*;

  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW    = 12;
  localparam int N_RANDOM  = 1600;
  localparam int PAGE_SPAN = 1 << (IMM_W - MEM_AW);
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = FUNC_W'(FN_JAL + 1);
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = '1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [REG_AW-1:0] dest;
    logic [REG_AW-1:0] src1;
    logic [REG_AW-1:0] src2;
    logic [IMM_W-1:0]  imm;
  } instr_t;

  typedef struct packed {
    instr_t  ins;
    logic    typed;
    result_t res;
  } stim_row_t;

  logic clk;
  logic rst;
  bit   calm;
  int   mismatch_count;

  // architectural copy kept by the predictor
  logic [XLEN-1:0] xregs [32];
  logic [XLEN-1:0] pc_model;
  logic [7:0]      dmem [MEM_BYTES];
  bit              dmem_written [MEM_BYTES];
  int              scattered_spots [$];
  result_t         pending_results [$];

  rvex_instr_if  instr_ch ();
  rvex_result_if result_ch ();

  rv32i_execute_unit #(.MEM_BYTES(MEM_BYTES)) dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  // directed part: only the rows whose outcome is obvious carry a typed result
  stim_row_t dir_tab [] = '{
    '{'{FN_ADD,   5'd1,  5'd0,  5'd0,  21'd0},        1'b1,
      '{1'b1, 5'd1, 32'h0000_0000, 32'd4,  1'b0}},
    '{'{FN_ADDI,  5'd0,  5'd0,  5'd0,  21'd5},        1'b1,
      '{1'b0, 5'd0, 32'h0000_0000, 32'd8,  1'b0}},
    '{'{FN_LUI,   5'd1,  5'd0,  5'd0,  21'h0F_FFFF},  1'b1,
      '{1'b1, 5'd1, 32'hFFFF_F000, 32'd12, 1'b0}},
    '{'{FN_ADDI,  5'd2,  5'd0,  5'd0,  21'h0F_FFFF},  1'b1,
      '{1'b1, 5'd2, 32'h000F_FFFF, 32'd16, 1'b0}},
    '{'{FN_ADDI,  5'd3,  5'd0,  5'd0,  21'h10_0000},  1'b1,
      '{1'b1, 5'd3, 32'hFFF0_0000, 32'd20, 1'b0}},
    '{'{FN_ADDI,  5'd5,  5'd0,  5'd0,  21'h1F_FFFF},  1'b1,
      '{1'b1, 5'd5, 32'hFFFF_FFFF, 32'd24, 1'b0}},
    '{'{FN_UNUSED_HI, 5'd9, 5'd5, 5'd5, 21'h1F_FFFF}, 1'b1,
      '{1'b0, 5'd0, 32'h0000_0000, 32'd28, 1'b0}},
    '{'{FN_LUI,   5'd4,  5'd0,  5'd0,  21'h10_0000},  1'b1,
      '{1'b1, 5'd4, 32'h0000_0000, 32'd32, 1'b0}},
    '{'{FN_AUIPC, 5'd6,  5'd0,  5'd0,  21'h0F_FFFF},  1'b1,
      '{1'b1, 5'd6, 32'hFFFF_F020, 32'd36, 1'b0}},
    '{'{FN_SUB,   5'd7,  5'd0,  5'd5,  21'd0},        1'b0, '0},
    '{'{FN_SLL,   5'd8,  5'd5,  5'd5,  21'd0},        1'b0, '0},
    '{'{FN_SLT,   5'd9,  5'd8,  5'd0,  21'd0},        1'b0, '0},
    '{'{FN_SLTU,  5'd10, 5'd8,  5'd0,  21'd0},        1'b0, '0},
    '{'{FN_XOR,   5'd11, 5'd1,  5'd2,  21'd0},        1'b0, '0},
    '{'{FN_SRL,   5'd12, 5'd1,  5'd5,  21'd0},        1'b0, '0},
    '{'{FN_SRA,   5'd13, 5'd1,  5'd5,  21'd0},        1'b0, '0},
    '{'{FN_OR,    5'd14, 5'd1,  5'd2,  21'd0},        1'b0, '0},
    '{'{FN_AND,   5'd15, 5'd1,  5'd3,  21'd0},        1'b0, '0},
    '{'{FN_SLTI,  5'd16, 5'd8,  5'd0,  21'h1F_FFFF},  1'b0, '0},
    '{'{FN_SLTIU, 5'd17, 5'd0,  5'd0,  21'h1F_FFFF},  1'b0, '0},
    '{'{FN_XORI,  5'd18, 5'd5,  5'd0,  21'h0F_FFFF},  1'b0, '0},
    '{'{FN_ORI,   5'd19, 5'd0,  5'd0,  21'h10_0000},  1'b0, '0},
    '{'{FN_ANDI,  5'd20, 5'd5,  5'd0,  21'h00_0555},  1'b0, '0},
    '{'{FN_SLLI,  5'd21, 5'd5,  5'd0,  21'd63},       1'b0, '0},
    '{'{FN_SRLI,  5'd22, 5'd8,  5'd0,  21'd33},       1'b0, '0},
    '{'{FN_SRAI,  5'd23, 5'd8,  5'd0,  21'h1F_FFFF},  1'b0, '0},
    '{'{FN_LUI,   5'd24, 5'd0,  5'd0,  21'h01_2345},  1'b0, '0},
    '{'{FN_ADDI,  5'd24, 5'd24, 5'd0,  21'h00_0678},  1'b0, '0},
    // word store straddling the top of memory
    '{'{FN_SW,    5'd0,  5'd0,  5'd24, 21'd4094},     1'b0, '0},
    '{'{FN_SB,    5'd0,  5'd0,  5'd5,  21'h1F_FFFF},  1'b0, '0},
    '{'{FN_SH,    5'd0,  5'd5,  5'd8,  21'd3},        1'b0, '0},
    '{'{FN_LW,    5'd25, 5'd0,  5'd0,  21'd4094},     1'b0, '0},
    '{'{FN_LB,    5'd26, 5'd0,  5'd0,  21'h1F_FFFF},  1'b0, '0},
    '{'{FN_LH,    5'd27, 5'd0,  5'd0,  21'd4095},     1'b0, '0},
    '{'{FN_LBU,   5'd28, 5'd5,  5'd0,  21'd0},        1'b0, '0},
    '{'{FN_LHU,   5'd29, 5'd0,  5'd0,  21'd1},        1'b0, '0},
    '{'{FN_BEQ,   5'd0,  5'd0,  5'd0,  21'd8},        1'b0, '0},
    '{'{FN_BNE,   5'd0,  5'd1,  5'd1,  21'd8},        1'b0, '0},
    '{'{FN_BLT,   5'd0,  5'd5,  5'd0,  21'h1F_FFFC},  1'b0, '0},
    '{'{FN_BGE,   5'd0,  5'd0,  5'd5,  21'h10_0000},  1'b0, '0},
    '{'{FN_BLTU,  5'd0,  5'd0,  5'd5,  21'h0F_FFFE},  1'b0, '0},
    '{'{FN_BGEU,  5'd0,  5'd0,  5'd5,  21'd16},       1'b0, '0},
    '{'{FN_JAL,   5'd30, 5'd0,  5'd0,  21'h1F_FFF8},  1'b0, '0},
    '{'{FN_JALR,  5'd31, 5'd5,  5'd0,  21'd0},        1'b0, '0},
    // link register is also the base: target uses the old value
    '{'{FN_JALR,  5'd31, 5'd31, 5'd0,  21'd3},        1'b0, '0},
    '{'{FN_JAL,   5'd0,  5'd0,  5'd0,  21'h0F_FFFF},  1'b0, '0}
  };

  function automatic logic [XLEN-1:0] read_xreg(logic [REG_AW-1:0] idx);
    return (idx == '0) ? '0 : xregs[idx];
  endfunction

  function automatic logic signed_less(logic [XLEN-1:0] x, logic [XLEN-1:0] y);
    return (x ^ 32'h8000_0000) < (y ^ 32'h8000_0000);
  endfunction

  function automatic logic [XLEN-1:0] shift_arith(logic [XLEN-1:0] x, logic [4:0] sh);
    return (x >> sh) | ({XLEN{x[XLEN-1]}} & ~(32'hFFFF_FFFF >> sh));
  endfunction

  function automatic logic [XLEN-1:0] load_le(logic [XLEN-1:0] ea, int nbytes);
    logic [XLEN-1:0]   v;
    logic [MEM_AW-1:0] addr;
    v = '0;
    for (int i = 0; i < nbytes; i++) begin
      addr = MEM_AW'(ea + 32'(i));
      v = v | (32'(dmem[addr]) << (8 * i));
    end
    return v;
  endfunction

  function automatic void store_le(logic [XLEN-1:0] ea, logic [XLEN-1:0] v, int nbytes);
    logic [MEM_AW-1:0] addr;
    for (int i = 0; i < nbytes; i++) begin
      addr = MEM_AW'(ea + 32'(i));
      dmem[addr] = v[8*i +: 8];
      dmem_written[addr] = 1'b1;
    end
  endfunction

  // executes one instruction on the local copy and returns the result it must produce
  function automatic result_t execute_instr(instr_t ins);
    logic [XLEN-1:0] a, b, imm, opnd, ea, val, npc;
    logic            wr, taken, cond;
    result_t         r;
    a     = read_xreg(ins.src1);
    b     = read_xreg(ins.src2);
    imm   = {{(XLEN-IMM_W){ins.imm[IMM_W-1]}}, ins.imm};
    opnd  = (ins.func <= FN_AND) ? b : imm;
    ea    = a + imm;
    val   = '0;
    wr    = 1'b0;
    taken = 1'b0;
    cond  = 1'b0;
    npc   = pc_model + 32'd4;
    case (ins.func)
      FN_ADD, FN_ADDI:   begin val = a + opnd; wr = 1'b1; end
      FN_SUB:            begin val = a - b; wr = 1'b1; end
      FN_SLL, FN_SLLI:   begin val = a << opnd[4:0]; wr = 1'b1; end
      FN_SLT, FN_SLTI:   begin val = {31'd0, signed_less(a, opnd)}; wr = 1'b1; end
      FN_SLTU, FN_SLTIU: begin val = {31'd0, a < opnd}; wr = 1'b1; end
      FN_XOR, FN_XORI:   begin val = a ^ opnd; wr = 1'b1; end
      FN_SRL, FN_SRLI:   begin val = a >> opnd[4:0]; wr = 1'b1; end
      FN_SRA, FN_SRAI:   begin val = shift_arith(a, opnd[4:0]); wr = 1'b1; end
      FN_OR, FN_ORI:     begin val = a | opnd; wr = 1'b1; end
      FN_AND, FN_ANDI:   begin val = a & opnd; wr = 1'b1; end
      FN_LB: begin
        val = load_le(ea, 1);
        val = {{24{val[7]}}, val[7:0]};
        wr  = 1'b1;
      end
      FN_LH: begin
        val = load_le(ea, 2);
        val = {{16{val[15]}}, val[15:0]};
        wr  = 1'b1;
      end
      FN_LW:  begin val = load_le(ea, 4); wr = 1'b1; end
      FN_LBU: begin val = load_le(ea, 1); wr = 1'b1; end
      FN_LHU: begin val = load_le(ea, 2); wr = 1'b1; end
      FN_JALR: begin
        val   = pc_model + 32'd4;
        wr    = 1'b1;
        npc   = {ea[XLEN-1:1], 1'b0};
        taken = 1'b1;
      end
      FN_SB:    store_le(ea, b, 1);
      FN_SH:    store_le(ea, b, 2);
      FN_SW:    store_le(ea, b, 4);
      FN_BEQ:   cond = (a == b);
      FN_BNE:   cond = (a != b);
      FN_BLT:   cond = signed_less(a, b);
      FN_BGE:   cond = !signed_less(a, b);
      FN_BLTU:  cond = (a < b);
      FN_BGEU:  cond = (a >= b);
      FN_LUI:   begin val = {ins.imm[19:0], 12'h000}; wr = 1'b1; end
      FN_AUIPC: begin val = pc_model + {ins.imm[19:0], 12'h000}; wr = 1'b1; end
      FN_JAL: begin
        val   = pc_model + 32'd4;
        wr    = 1'b1;
        npc   = pc_model + imm;
        taken = 1'b1;
      end
      default: ;
    endcase
    if (cond) begin
      npc   = pc_model + imm;
      taken = 1'b1;
    end
    if (wr && ins.dest != '0) begin
      xregs[ins.dest] = val;
      r.reg_write     = 1'b1;
      r.write_index   = ins.dest;
      r.write_value   = val;
    end else begin
      r.reg_write   = 1'b0;
      r.write_index = '0;
      r.write_value = '0;
    end
    r.next_pc      = npc;
    r.branch_taken = taken;
    pc_model       = npc;
    return r;
  endfunction

  // half the picks come from x0..x4, the rest from x0..x31, so back-to-back dependencies are frequent
  function automatic logic [REG_AW-1:0] pick_reg();
    if ($urandom_range(0, 1) == 0)
      return REG_AW'($urandom_range(0, 4));
    return REG_AW'($urandom_range(0, 31));
  endfunction

  function automatic logic [IMM_W-1:0] rand_imm();
    case ($urandom_range(0, 3))
      0: return IMM_W'($urandom_range(0, 64)) - IMM_W'(32);
      1: begin
        case ($urandom_range(0, 3))
          0:       return {1'b1, 20'd0};
          1:       return {1'b0, {20{1'b1}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return IMM_W'($urandom);
    endcase
  endfunction

  // hot window across the wrap point of memory
  function automatic int window_spot();
    return (MEM_BYTES - 32 + int'($urandom_range(0, 63))) % MEM_BYTES;
  endfunction

  // offset that lands base + offset on the target byte, with a random page on top
  function automatic logic [IMM_W-1:0] imm_toward(logic [XLEN-1:0] base, int target);
    logic [MEM_AW-1:0] gap;
    int                page;
    gap  = MEM_AW'(target) - base[MEM_AW-1:0];
    page = int'($urandom_range(0, PAGE_SPAN - 1)) - PAGE_SPAN / 2;
    return IMM_W'(page * MEM_BYTES + int'(gap));
  endfunction

  // tries up to 16 spots for an address whose bytes have all been written
  function automatic bit pick_readable(int nbytes, output int target);
    int cand;
    bit ok;
    for (int t = 0; t < 16; t++) begin
      if (scattered_spots.size() != 0 && $urandom_range(0, 3) == 0)
        cand = scattered_spots[$urandom_range(0, scattered_spots.size() - 1)];
      else
        cand = window_spot();
      ok = 1'b1;
      for (int i = 0; i < nbytes; i++)
        if (!dmem_written[(cand + i) % MEM_BYTES]) ok = 1'b0;
      if (ok) begin
        target = cand;
        return 1'b1;
      end
    end
    target = 0;
    return 1'b0;
  endfunction

  function automatic instr_t rand_instr();
    instr_t ins;
    int     pick, target, nbytes;
    ins.func = FN_ADD;
    ins.dest = pick_reg();
    ins.src1 = pick_reg();
    ins.src2 = pick_reg();
    ins.imm  = rand_imm();
    pick     = $urandom_range(0, 99);
    if (pick < 16) begin
      ins.func = FUNC_W'($urandom_range(FN_ADD, FN_AND));
    end else if (pick < 36) begin
      ins.func = FUNC_W'($urandom_range(FN_ADDI, FN_SRAI));
    end else if (pick < 50) begin
      ins.func = FUNC_W'($urandom_range(FN_LB, FN_LHU));
      nbytes = (ins.func == FN_LW) ? 4 : (ins.func == FN_LB || ins.func == FN_LBU) ? 1 : 2;
      if (pick_readable(nbytes, target))
        ins.imm = imm_toward(read_xreg(ins.src1), target);
      else
        ins.func = FN_SW;
    end else if (pick < 64) begin
      ins.func = FUNC_W'($urandom_range(FN_SB, FN_SW));
      if ($urandom_range(0, 7) == 0) begin
        target = $urandom_range(0, MEM_BYTES - 1);
        scattered_spots.push_back(target);
        if (scattered_spots.size() > 64) void'(scattered_spots.pop_front());
      end else begin
        target = window_spot();
      end
      ins.imm = imm_toward(read_xreg(ins.src1), target);
    end else if (pick < 78) begin
      ins.func = FUNC_W'($urandom_range(FN_BEQ, FN_BGEU));
      if ($urandom_range(0, 3) == 0) ins.src2 = ins.src1;
    end else if (pick < 84) begin
      ins.func = ($urandom_range(0, 1) == 0) ? FN_JAL : FN_JALR;
    end else if (pick < 94) begin
      ins.func = ($urandom_range(0, 1) == 0) ? FN_LUI : FN_AUIPC;
    end else begin
      ins.func = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
    end
    return ins;
  endfunction

  task automatic flag_mismatch(string what, logic [XLEN-1:0] got, logic [XLEN-1:0] want);
    if (mismatch_count < 200)
      $display("mismatch %s: got %h, want %h", what, got, want);
    mismatch_count++;
  endtask

  // presents one instruction, holds it until the transaction, then records its result
  task automatic send_instr(instr_t ins, logic typed, result_t typed_res);
    result_t r;
    while (!calm && $urandom_range(0, 99) < 19) begin
      instr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    instr_ch.valid      <= 1'b1;
    instr_ch.func       <= ins.func;
    instr_ch.dest_index <= ins.dest;
    instr_ch.src1_index <= ins.src1;
    instr_ch.src2_index <= ins.src2;
    instr_ch.immediate  <= ins.imm;
    do @(posedge clk); while (!instr_ch.ready);
    r = execute_instr(ins);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[rv32i_execute_unit] ERROR");
    $finish;
  end

  initial result_ch.ready = 1'b0;

  always @(posedge clk)
    result_ch.ready <= calm || ($urandom_range(0, 99) >= 19);

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected transaction", result_ch.next_pc, '0);
      end else begin
        want = pending_results.pop_front();
        if (result_ch.reg_write !== want.reg_write)
          flag_mismatch("reg_write", 32'(result_ch.reg_write), 32'(want.reg_write));
        if (result_ch.write_index !== want.write_index)
          flag_mismatch("write_index", 32'(result_ch.write_index), 32'(want.write_index));
        if (result_ch.write_value !== want.write_value)
          flag_mismatch("write_value", result_ch.write_value, want.write_value);
        if (result_ch.next_pc !== want.next_pc)
          flag_mismatch("next_pc", result_ch.next_pc, want.next_pc);
        if (result_ch.branch_taken !== want.branch_taken)
          flag_mismatch("branch_taken", 32'(result_ch.branch_taken), 32'(want.branch_taken));
      end
    end
  end

  initial begin
    rst                 <= 1'b1;
    calm                 = 1'b0;
    mismatch_count       = 0;
    instr_ch.valid      <= 1'b0;
    instr_ch.func       <= FN_ADD;
    instr_ch.dest_index <= '0;
    instr_ch.src1_index <= '0;
    instr_ch.src2_index <= '0;
    instr_ch.immediate  <= '0;
    pc_model             = '0;
    for (int i = 0; i < 32; i++) xregs[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) begin
      dmem[i]         = 8'h00;
      dmem_written[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      send_instr(dir_tab[i].ins, dir_tab[i].typed, dir_tab[i].res);

    for (int i = 0; i < N_RANDOM; i++) begin
      // a long stretch with no idling on either side
      calm = (i >= 700 && i < 1000);
      send_instr(rand_instr(), 1'b0, '0);
    end
    calm = 1'b0;
    instr_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("[rv32i_execute_unit] OK");
    else
      $display("[rv32i_execute_unit] ERROR");
    $finish;
  end

endmodule
